[rtl/core/aes128_pkg.sv]
// Shared constants, types and byte-level helper functions for the AES-128 core.
package aes128_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int RK_ROWS     = ROUND_COUNT + 1;
    localparam int RK_IDX_W    = $clog2(RK_ROWS);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [7:0] GF_POLY_LOW = 8'h1B;
    localparam logic [7:0] GF_MSB      = 8'h80;

    typedef logic [127:0] block_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        logic [7:0] sh;
        sh = {a[6:0], 1'b0};
        return ((a & GF_MSB) != 8'h00) ? (sh ^ GF_POLY_LOW) : sh;
    endfunction

    // Inverse of the S-box affine map.
    function automatic logic [7:0] inv_affine(input logic [7:0] s);
        return {s[6:0], s[7]} ^ {s[4:0], s[7:5]} ^ {s[1:0], s[7:2]} ^ 8'h05;
    endfunction

    // Forward S-box, or inverse S-box built from the forward table.
    function automatic logic [7:0] sub_byte(input logic [7:0] x, input logic inverse);
        logic [7:0] y;
        y = SBOX[inverse ? inv_affine(x) : x];
        return inverse ? inv_affine(y) : y;
    endfunction

    function automatic logic [7:0] get_byte(input block_t s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic block_t sub_block(input block_t s, input logic inverse);
        block_t t;
        for (int i = 0; i < 16; i++)
        begin
            t[127-8*i -: 8] = sub_byte(get_byte(s, i), inverse);
        end
        return t;
    endfunction

    function automatic block_t shift_rows(input block_t s, input logic inverse);
        block_t t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (inverse)
                begin
                    t[127-8*(r+4*c) -: 8] = get_byte(s, r + 4*((c - r + 4) % 4));
                end
                else
                begin
                    t[127-8*(r+4*c) -: 8] = get_byte(s, r + 4*((c + r) % 4));
                end
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_word(input logic [31:0] w, input logic inverse);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] m3 [4];
        logic [31:0] o;
        for (int k = 0; k < 4; k++)
        begin
            a[k]   = w[31-8*k -: 8];
            x2[k]  = xtime(a[k]);
            x4[k]  = xtime(x2[k]);
            x8[k]  = xtime(x4[k]);
            m3[k]  = x2[k] ^ a[k];
            m9[k]  = x8[k] ^ a[k];
            m11[k] = x8[k] ^ x2[k] ^ a[k];
            m13[k] = x8[k] ^ x4[k] ^ a[k];
            m14[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        for (int r = 0; r < 4; r++)
        begin
            if (inverse)
            begin
                o[31-8*r -: 8] = m14[r] ^ m11[(r+1)%4] ^ m13[(r+2)%4] ^ m9[(r+3)%4];
            end
            else
            begin
                o[31-8*r -: 8] = x2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
            end
        end
        return o;
    endfunction

    function automatic block_t mix_columns(input block_t s, input logic inverse);
        block_t t;
        for (int c = 0; c < 4; c++)
        begin
            t[127-32*c -: 32] = mix_word(s[127-32*c -: 32], inverse);
        end
        return t;
    endfunction

    // One step of the key schedule: the next round key from the previous one.
    function automatic block_t next_round_key(input block_t k, input logic [7:0] rcon);
        logic [31:0] w3;
        logic [31:0] t;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        w3 = k[31:0];
        t  = {sub_byte(w3[23:16], 1'b0), sub_byte(w3[15:8], 1'b0),
              sub_byte(w3[7:0], 1'b0), sub_byte(w3[31:24], 1'b0)};
        t  = t ^ {rcon, 24'h000000};
        n0 = k[127:96] ^ t;
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

[rtl/core/aes128_if.sv]
// Handshake channel interfaces for the AES-128 core: input, result and register write.
interface aes128_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] block_high;
    logic [63:0] block_low;

    modport source (output valid, output opcode, output block_high, output block_low,
                    input ready);
    modport sink   (input valid, input opcode, input block_high, input block_low,
                    output ready);
endinterface

interface aes128_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, output result_high, output result_low, input ready);
    modport sink   (input valid, input result_high, input result_low, output ready);
endinterface

interface aes128_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [aes128_pkg::CFG_IDX_W-1:0]   index;
    logic [63:0]                        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/aes128_block_cipher_core.sv]
// AES-128 encrypt/decrypt core with an iterative round datapath and stored key schedule.
//
// This core encrypts or decrypts one 128-bit block per transaction under the
// 128-bit key held in two 64-bit registers (index 0 is the upper half, index 1
// the lower half). After acceptance, a block reaches a valid result through the
// initial key addition and ten rounds, executed one per cycle, the last once the
// output register is free, on a single shared round unit (sixteen S-box lookups,
// ShiftRows and MixColumns in either direction). The round unit is not pipelined,
// so the input is ready only when no block is in flight; a finished result sits in
// an output register and the next block may be accepted while it waits to be
// taken. After reset, and after every key register write, the key schedule is
// expanded into an eleven-row round key store, one row per cycle; no block is
// accepted during the expansion. Register writes are accepted whenever no
// block is in the round unit; writes to other indices are ignored. While a
// register write is offered, the input is held off, so a block and a write are
// never accepted in the same cycle.
module aes128_block_cipher_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    aes128_in_if.sink            in_ch,
    aes128_out_if.source         out_ch,
    aes128_cfg_if.sink           cfg_ch
);

    localparam logic [1:0] ST_KEYEXP = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_ROUND  = 2'd2;

    localparam logic [aes128_pkg::RK_IDX_W-1:0] LAST_ROUND =
        aes128_pkg::RK_IDX_W'(aes128_pkg::ROUND_COUNT);

    logic [1:0]                           state_reg, state_next;
    logic [aes128_pkg::RK_IDX_W-1:0]      round_reg, round_next;
    logic [aes128_pkg::RK_IDX_W-1:0]      kcnt_reg, kcnt_next;
    logic                                 out_valid_reg, out_valid_next;
    logic                                 decrypt_reg;
    logic [63:0]                          key_high_reg;
    logic [63:0]                          key_low_reg;
    logic [7:0]                           rcon_reg;
    aes128_pkg::block_t                   kwork_reg;
    aes128_pkg::block_t                   data_reg;
    aes128_pkg::block_t                   result_reg;
    aes128_pkg::block_t                   rk_mem [aes128_pkg::RK_ROWS];

    aes128_pkg::block_t                   round_key;
    aes128_pkg::block_t                   key_next_row;
    aes128_pkg::block_t                   sub_shift;
    aes128_pkg::block_t                   round_out;
    logic [aes128_pkg::RK_IDX_W-1:0]      rk_index;
    logic                                 in_fire;
    logic                                 out_fire;
    logic                                 cfg_fire;
    logic                                 key_write;
    logic                                 round_done;

    assign in_ch.ready  = (state_reg == ST_IDLE) && !cfg_ch.valid;
    assign cfg_ch.ready = (state_reg != ST_ROUND);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_fire     = out_ch.valid && out_ch.ready;
    assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
    assign key_write    = cfg_fire && ((cfg_ch.index == aes128_pkg::REG_KEY_HIGH) ||
                                       (cfg_ch.index == aes128_pkg::REG_KEY_LOW));

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.result_high = result_reg[127:64];
    assign out_ch.result_low  = result_reg[63:0];

    // Decryption walks the key schedule from the last row back to the first.
    assign rk_index  = decrypt_reg ? (LAST_ROUND - round_reg) : round_reg;
    assign round_key = rk_mem[rk_index];

    assign key_next_row = aes128_pkg::next_round_key(kwork_reg, rcon_reg);

    // Shared round unit. Step zero is the initial key addition; the last step
    // skips MixColumns. Encryption mixes before the key, decryption after.
    always_comb
    begin
        sub_shift = aes128_pkg::shift_rows(aes128_pkg::sub_block(data_reg, decrypt_reg),
                                           decrypt_reg);
        if (round_reg == '0)
        begin
            round_out = data_reg ^ round_key;
        end
        else if (round_reg == LAST_ROUND)
        begin
            round_out = sub_shift ^ round_key;
        end
        else if (decrypt_reg)
        begin
            round_out = aes128_pkg::mix_columns(sub_shift ^ round_key, 1'b1);
        end
        else
        begin
            round_out = aes128_pkg::mix_columns(sub_shift, 1'b0) ^ round_key;
        end
    end

    // The final step may only retire when the output register is free.
    assign round_done = (state_reg == ST_ROUND) && (round_reg == LAST_ROUND) &&
                        (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        kcnt_next      = kcnt_reg;
        out_valid_next = out_valid_reg;
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_KEYEXP:
            begin
                kcnt_next = kcnt_reg + 1'b1;
                if (kcnt_reg == LAST_ROUND)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_ROUND;
                    round_next = '0;
                end
            end
            ST_ROUND:
            begin
                if (round_done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
                else if (round_reg != LAST_ROUND)
                begin
                    round_next = round_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_KEYEXP;
            end
        endcase
        // A key write restarts the schedule expansion from the first row.
        if (key_write)
        begin
            state_next = ST_KEYEXP;
            kcnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_KEYEXP;
            round_reg     <= '0;
            kcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            key_high_reg  <= '0;
            key_low_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            kcnt_reg      <= kcnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_fire && (cfg_ch.index == aes128_pkg::REG_KEY_HIGH))
            begin
                key_high_reg <= cfg_ch.data;
            end
            if (cfg_fire && (cfg_ch.index == aes128_pkg::REG_KEY_LOW))
            begin
                key_low_reg <= cfg_ch.data;
            end
        end
    end

    // Datapath registers and the round key store carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            data_reg    <= {in_ch.block_high, in_ch.block_low};
            decrypt_reg <= (in_ch.opcode == aes128_pkg::OP_DECRYPT);
        end
        else if ((state_reg == ST_ROUND) && (round_reg != LAST_ROUND))
        begin
            data_reg <= round_out;
        end
        if (round_done)
        begin
            result_reg <= round_out;
        end
        if ((state_reg == ST_KEYEXP) && !key_write)
        begin
            if (kcnt_reg == '0)
            begin
                rk_mem[0] <= {key_high_reg, key_low_reg};
                kwork_reg <= {key_high_reg, key_low_reg};
                rcon_reg  <= 8'h01;
            end
            else
            begin
                rk_mem[kcnt_reg] <= key_next_row;
                kwork_reg        <= key_next_row;
                rcon_reg         <= aes128_pkg::xtime(rcon_reg);
            end
        end
    end

    // An accepted block always enters the round unit at its first step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !key_write |=> (state_reg == ST_ROUND) && (round_reg == '0))
        else $error("accepted block did not start at the first round step");

    // The step counter never runs past the last round.
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg <= LAST_ROUND))
        else $error("round counter out of range");

    // A result is only loaded into a free or draining output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        round_done |-> (!out_valid_reg || out_ch.ready))
        else $error("result overwrote a pending transaction");

    // Blocks are never accepted while the key schedule is being expanded.
    a_no_accept_in_keyexp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEYEXP) |-> !in_ch.ready)
        else $error("input ready during key expansion");

endmodule
